// ----- rtl/rid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_pkg
// shared types and constants of the rca ir frame decoder
// ----------------------------------------------------------------------------
package rid_pkg;

    localparam int DUR_W      = 16;
    localparam int WIN_W      = 16;
    localparam int POS_W      = 8;
    localparam int STORE_W    = 24;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [POS_W-1:0]   FIRST_GAP_POS = 8'd3;
    localparam logic [POS_W-1:0]   POS_MAX       = 8'd255;
    localparam logic [COUNT_W-1:0] FRAME_BITS    = 5'd24;
    localparam logic [COUNT_W-1:0] TOP_BIT       = 5'd23;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX  = 2'd3;

    localparam logic [WIN_W-1:0] ZERO_MIN_RST = 16'd800;
    localparam logic [WIN_W-1:0] ZERO_MAX_RST = 16'd1200;
    localparam logic [WIN_W-1:0] ONE_MIN_RST  = 16'd1600;
    localparam logic [WIN_W-1:0] ONE_MAX_RST  = 16'd2400;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             frame_end;
    } rid_in_t;

    typedef struct packed {
        logic [7:0]         address;
        logic [7:0]         command;
        logic [7:0]         check_byte;
        logic [COUNT_W-1:0] bits_decoded;
        logic               stopped_early;
    } rid_out_t;

    typedef struct packed {
        logic [WIN_W-1:0] zero_min;
        logic [WIN_W-1:0] zero_max;
        logic [WIN_W-1:0] one_min;
        logic [WIN_W-1:0] one_max;
    } rid_window_t;

    typedef struct packed {
        logic hit_zero;
        logic hit_one;
    } rid_gap_class_t;

endpackage

// ----- rtl/rid_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_cfg_regs
// gap window registers, written through the plain write port
// ----------------------------------------------------------------------------
module rid_cfg_regs
    import rid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]     cfg_wdata,
    output rid_window_t          windows
);

    rid_window_t win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.zero_min <= ZERO_MIN_RST;
            win_reg.zero_max <= ZERO_MAX_RST;
            win_reg.one_min  <= ONE_MIN_RST;
            win_reg.one_max  <= ONE_MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ZERO_MIN: win_reg.zero_min <= cfg_wdata;
                REG_ZERO_MAX: win_reg.zero_max <= cfg_wdata;
                REG_ONE_MIN:  win_reg.one_min  <= cfg_wdata;
                REG_ONE_MAX:  win_reg.one_max  <= cfg_wdata;
                default:      win_reg <= win_reg;
            endcase
        end
    end

    assign windows = win_reg;

endmodule

// ----- rtl/rid_gap_class.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_gap_class
// window compares of one gap duration, zero window first
// ----------------------------------------------------------------------------
module rid_gap_class
    import rid_pkg::*;
(
    input  logic [DUR_W-1:0] gap,
    input  rid_window_t      windows,
    output rid_gap_class_t   gap_class
);

    logic in_zero;
    logic in_one;

    always_comb
    begin
        in_zero = (gap >= windows.zero_min) && (gap <= windows.zero_max);
        in_one  = (gap >= windows.one_min) && (gap <= windows.one_max);
        gap_class.hit_zero = in_zero;
        gap_class.hit_one  = !in_zero && in_one;
    end

endmodule

// ----- rtl/rid_frame_acc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_frame_acc
// frame state: item position, bit store, bit count and stop flag;
// forms the result word from the updated state on the last item
// ----------------------------------------------------------------------------
module rid_frame_acc
    import rid_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           frame_end,
    input  rid_gap_class_t gap_class,
    output rid_out_t       result_next
);

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [STORE_W-1:0] store_reg;
    logic [STORE_W-1:0] store_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               stop_reg;
    logic               stop_next;

    logic [STORE_W-1:0] store_upd;
    logic [COUNT_W-1:0] count_upd;
    logic               stop_upd;
    logic               take_gap;
    logic [COUNT_W-1:0] bit_idx;
    logic [7:0]         b0;
    logic [7:0]         b1;

    always_comb
    begin
        take_gap  = (pos_reg >= FIRST_GAP_POS) && pos_reg[0] && !stop_reg
                    && (count_reg < FRAME_BITS);
        bit_idx   = TOP_BIT - count_reg;
        store_upd = store_reg;
        count_upd = count_reg;
        stop_upd  = stop_reg;
        if (take_gap)
        begin
            if (gap_class.hit_zero || gap_class.hit_one)
            begin
                count_upd = count_reg + 5'd1;
                if (gap_class.hit_one)
                begin
                    store_upd[bit_idx] = 1'b1;
                end
            end
            else
            begin
                stop_upd = 1'b1;
            end
        end

        b0 = store_upd[23:16];
        b1 = store_upd[15:8];
        result_next.address       = {b1[3:0], b0[7:4]};
        result_next.command       = {b0[3:0], b1[7:4]};
        result_next.check_byte    = store_upd[7:0];
        result_next.bits_decoded  = count_upd;
        result_next.stopped_early = stop_upd;

        pos_next   = pos_reg;
        store_next = store_reg;
        count_next = count_reg;
        stop_next  = stop_reg;
        if (step)
        begin
            if (frame_end)
            begin
                pos_next   = '0;
                store_next = '0;
                count_next = '0;
                stop_next  = 1'b0;
            end
            else
            begin
                pos_next   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 8'd1;
                store_next = store_upd;
                count_next = count_upd;
                stop_next  = stop_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            store_reg <= '0;
            count_reg <= '0;
            stop_reg  <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            store_reg <= store_next;
            count_reg <= count_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

// ----- rtl/rca_ir_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_ir_frame_decoder
// decodes an rca infrared frame from a stream of pulse and gap durations
//
//   channel   direction  handshake            word
//   item      in         item_valid/stall     rid_in_t  (duration, frame_end)
//   result    out        result_valid/stall   rid_out_t (one per frame)
//   cfg       in         cfg_wr_en            cfg_index, cfg_wdata
//
// one word per cycle sustained while no result waits on result_stall; the last
// word of a frame goes through the input register, then the result register
// rst_n clears the frame state and loads the default gap windows
// item_stall rises only while the input register is full and a result waits
// on result_stall
// ----------------------------------------------------------------------------
module rca_ir_frame_decoder
    import rid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  rid_in_t              item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output rid_out_t             result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]     cfg_wdata
);

    rid_in_t        item_reg;
    logic           item_valid_reg;
    rid_out_t       result_reg;
    logic           result_valid_reg;
    rid_window_t    windows;
    rid_gap_class_t gap_class;
    rid_out_t       result_next;
    logic           advance;
    logic           step;
    logic           take_item;

    assign advance    = !result_valid_reg || !result_stall;
    assign step       = item_valid_reg && advance;
    assign item_stall = item_valid_reg && !advance;
    assign take_item  = item_valid && !item_stall;

    rid_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .windows   (windows)
    );

    rid_gap_class u_class (
        .gap       (item_reg.duration),
        .windows   (windows),
        .gap_class (gap_class)
    );

    rid_frame_acc u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .frame_end   (item_reg.frame_end),
        .gap_class   (gap_class),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= take_item || (item_valid_reg && !step);
            if (advance)
            begin
                result_valid_reg <= item_valid_reg && item_reg.frame_end;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            item_reg <= item;
        end
        if (step && item_reg.frame_end)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
